### design/gvr_pkg.sv
// Shared constants, types and table functions for the gamma rejection step.
`timescale 1ns / 1ps
package gvr_pkg;

  localparam int UNIFORM_BITS = 32;
  localparam logic [31:0] UNIFORM_MASK = 32'((64'd1 << UNIFORM_BITS) - 64'd1);

  localparam int LOG_STEPS = 24;
  localparam int LOG_LAT   = LOG_STEPS + 1;
  localparam int EXP_STEPS = 24;
  localparam int EXP_LAT   = EXP_STEPS + 4;
  localparam int PIPE_LAST = LOG_LAT + 4 + EXP_LAT + 1;

  localparam logic [23:0] LN2_Q24     = 24'd11629080;
  localparam logic [24:0] LOG2E_Q24   = 25'd24204406;
  localparam logic [57:0] SQUEEZE_Q24 = 58'd42011447;
  localparam logic [31:0] LOG2_96_Q24 = 32'h6000_0000;
  localparam logic [24:0] LN4_Q16     = 25'd90852;
  localparam logic [40:0] CAND_MAX    = 41'd1 << 40;
  localparam logic [24:0] ONE_Q16     = 25'd65536;

  typedef struct packed {
    logic [23:0]        shape;
    logic [31:0]        inv;
    logic signed [24:0] offset;
    logic [24:0]        slope;
  } gvr_terms_t;

  localparam gvr_terms_t TERMS_RESET = '{
    shape:  24'd65536,
    inv:    32'd65536,
    offset: -25'sd25316,
    slope:  25'd131072
  };

  typedef struct packed {
    logic signed [55:0] sterm;
    logic signed [31:0] lnz;
    logic [31:0]        zq;
  } gvr_side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = x;
    res = '0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  function automatic logic [30:0] pow2_tab(input int idx);
    logic [63:0] t;
    t = isqrt64(64'd1 << 61);
    for (int j = 1; j <= idx; j++) begin
      t = isqrt64(t << 30);
    end
    return t[30:0];
  endfunction

  function automatic logic [31:0] norm_uniform(input logic [31:0] raw);
    return (raw & UNIFORM_MASK) << (32 - UNIFORM_BITS);
  endfunction

endpackage

### design/gvr_derive.sv
// Shape register and sequential derivation of the envelope terms.
`timescale 1ns / 1ps
module gvr_derive
  import gvr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_data_i,
  output gvr_terms_t  terms_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQRT = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]  state_q;
  logic [5:0]  cnt_q;
  gvr_terms_t  terms_q;

  logic [23:0] a_q;
  logic [40:0] rad_q;
  logic [20:0] root_q;
  logic [20:0] aa_q;
  logic [20:0] rem_q;
  logic [32:0] quo_q;

  logic [23:0] a_in;
  logic [24:0] two_a;
  logic        big_in;
  logic [20:0] trial;
  logic [41:0] trial_sq;
  logic [20:0] root_d;
  logic [21:0] rem_sh;
  logic        q_bit;
  logic [20:0] rem_d;
  logic [32:0] quo_d;
  logic        cfg_xfer;

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign terms_o     = terms_q;

  assign a_in   = (cfg_data_i == 24'd0) ? 24'd1 : cfg_data_i;
  assign two_a  = {a_in, 1'b0};
  assign big_in = ({1'b0, a_in} > ONE_Q16);

  assign trial    = root_q | (21'd1 << cnt_q[4:0]);
  assign trial_sq = trial * trial;
  assign root_d   = (trial_sq <= {1'b0, rad_q}) ? trial : root_q;

  assign rem_sh = {rem_q, (cnt_q == 6'd32)};
  assign q_bit  = (rem_sh >= {1'b0, aa_q});
  assign rem_d  = q_bit ? 21'(rem_sh - {1'b0, aa_q}) : rem_sh[20:0];
  assign quo_d  = {quo_q[31:0], q_bit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      terms_q <= TERMS_RESET;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cfg_xfer) begin
            if (big_in) begin
              state_q <= ST_SQRT;
              cnt_q   <= 6'd20;
            end else begin
              state_q <= ST_DIV;
              cnt_q   <= 6'd32;
            end
          end
        end
        ST_SQRT: begin
          if (cnt_q == 6'd0) begin
            state_q <= ST_DIV;
            cnt_q   <= 6'd32;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        ST_DIV: begin
          if (cnt_q == 6'd0) begin
            state_q       <= ST_IDLE;
            terms_q.shape <= a_q;
            terms_q.inv   <= quo_d[32] ? 32'hFFFF_FFFF : quo_d[31:0];
            terms_q.offset <= $signed({1'b0, a_q}) - $signed(LN4_Q16);
            terms_q.slope <= {1'b0, a_q} + {4'd0, aa_q};
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (cfg_xfer) begin
          a_q    <= a_in;
          rad_q  <= {25'(two_a - ONE_Q16), 16'd0};
          root_q <= '0;
          aa_q   <= a_in[20:0];
          rem_q  <= '0;
          quo_q  <= '0;
        end
      end
      ST_SQRT: begin
        root_q <= root_d;
        if (cnt_q == 6'd0) begin
          aa_q <= root_d;
        end
      end
      ST_DIV: begin
        rem_q <= rem_d;
        quo_q <= quo_d;
      end
      default: begin
        root_q <= root_q;
      end
    endcase
  end

endmodule

### design/gvr_log2.sv
// Pipelined base-2 logarithm, Q.24 result, one squaring step per stage.
`timescale 1ns / 1ps
module gvr_log2
  import gvr_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] x_i,
  output logic [28:0] lg_o
);

  logic [4:0]  msb;
  logic [31:0] shl;

  logic [30:0] y_q [LOG_STEPS+1];
  logic [4:0]  p_q [LOG_STEPS+1];
  logic [23:0] f_q [LOG_STEPS+1];

  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (x_i[i]) msb = 5'(i);
    end
  end

  assign shl = x_i << (5'd31 - msb);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q[0] <= shl[31:1];
      p_q[0] <= msb;
      f_q[0] <= '0;
    end
  end

  for (genvar s = 1; s <= LOG_STEPS; s++) begin : g_step
    logic [61:0] sq;
    logic [31:0] t;
    assign sq = y_q[s-1] * y_q[s-1];
    assign t  = sq[61:30];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        y_q[s] <= t[31] ? t[31:1] : t[30:0];
        p_q[s] <= p_q[s-1];
        f_q[s] <= {f_q[s-1][22:0], t[31]};
      end
    end
  end

  assign lg_o = {p_q[LOG_STEPS], f_q[LOG_STEPS]};

endmodule

### design/gvr_exp.sv
// Pipelined candidate a*exp(v) in Q.24 with side payload carried alongside.
`timescale 1ns / 1ps
module gvr_exp
  import gvr_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic        v_neg_i,
  input  logic [44:0] v_mag_i,
  input  logic [23:0] shape_i,
  input  gvr_side_t   side_i,
  output logic [40:0] x_o,
  output gvr_side_t   side_o
);

  logic        hi_in;
  logic        lo_in;
  logic [57:0] tprod;

  logic        hi0_q;
  logic        lo0_q;
  logic        tneg0_q;
  logic [32:0] tmag0_q;
  logic [33:0] ts;

  logic [30:0]        m_q  [1:EXP_STEPS+1];
  logic [23:0]        f_q  [1:EXP_STEPS+1];
  logic signed [9:0]  k_q  [1:EXP_STEPS+1];
  logic               hi_q [1:EXP_STEPS+1];
  logic               lo_q [1:EXP_STEPS+1];

  logic [54:0]       prod_q;
  logic signed [9:0] kp_q;
  logic              hip_q;
  logic              lop_q;

  logic signed [10:0] sh;
  logic [10:0]        nl;
  logic [63:0]        xs;
  logic [63:0]        pw;
  logic [40:0]        x_d;
  logic [40:0]        x_q;

  gvr_side_t side_q [EXP_LAT];

  localparam logic [63:0] CAND64 = 64'd1 << 40;

  assign hi_in = !v_neg_i && (v_mag_i[44:31] != 14'd0);
  assign lo_in = v_neg_i && (v_mag_i > 45'd2147483648);
  assign tprod = v_mag_i[31:0] * LOG2E_Q24 + (58'd1 << 23);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi0_q   <= hi_in;
      lo0_q   <= lo_in;
      tneg0_q <= v_neg_i;
      tmag0_q <= tprod[56:24];
    end
  end

  assign ts = tneg0_q ? 34'(-{1'b0, tmag0_q}) : {1'b0, tmag0_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[1]  <= 31'd1 << 30;
      f_q[1]  <= ts[23:0];
      k_q[1]  <= ts[33:24];
      hi_q[1] <= hi0_q;
      lo_q[1] <= lo0_q;
    end
  end

  for (genvar s = 1; s <= EXP_STEPS; s++) begin : g_step
    localparam logic [30:0] TAB = pow2_tab(s - 1);
    logic [61:0] mp;
    assign mp = m_q[s] * TAB;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[s+1]  <= f_q[s][24-s] ? mp[60:30] : m_q[s];
        f_q[s+1]  <= f_q[s];
        k_q[s+1]  <= k_q[s];
        hi_q[s+1] <= hi_q[s];
        lo_q[s+1] <= lo_q[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= shape_i * m_q[EXP_STEPS+1];
      kp_q   <= k_q[EXP_STEPS+1];
      hip_q  <= hi_q[EXP_STEPS+1];
      lop_q  <= lo_q[EXP_STEPS+1];
    end
  end

  always_comb begin
    sh = 11'sd22 - 11'(kp_q);
    nl = 11'(-sh);
    pw = {9'd0, prod_q};
    if (!sh[10]) begin
      if (sh > 11'sd54) xs = '0;
      else xs = pw >> sh[5:0];
    end else begin
      if (nl >= 11'd40) xs = CAND64;
      else if (pw > (CAND64 >> nl[5:0])) xs = CAND64;
      else xs = pw << nl[5:0];
    end
    if (xs > CAND64) xs = CAND64;
    if (hip_q) x_d = CAND_MAX;
    else if (lop_q) x_d = '0;
    else x_d = xs[40:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      side_q[0] <= side_i;
      for (int i = 1; i < EXP_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign x_o    = x_q;
  assign side_o = side_q[EXP_LAT-1];

endmodule

### design/gamma_variate_rejection_step.sv
// Top level of the gamma rejection step: input stage, test datapath, output register.
`timescale 1ns / 1ps
// One attempt of the gamma rejection sampler per uniform pair: the block takes one pair
// (first_uniform in tdata[31:0], second_uniform in tdata[63:32]) in every unstalled cycle
// and emits a Q16.16 sample only when the attempt is accepted, so results are a thinned
// stream in input order. The delay from input transfer to a valid result is set mostly by
// the two 24-stage chains of the logarithm and the exponent. A stall at the output holds
// the whole pipeline. A shape write through the cfg channel recomputes the envelope terms
// with a bit-serial square root (shapes above 1.0) and divider, during which cfg_ready_o
// and s_axis_tready are low. Write the shape only while no attempts are in flight.
module gamma_variate_rejection_step
  import gvr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] first_uniform, [63:32] second_uniform
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] sample_q16
  output logic [0:0]  m_axis_tuser,  // [0] saturated
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_data_i
);

  gvr_terms_t terms;
  logic       en;
  logic       in_xfer;
  logic       in_live;
  logic [PIPE_LAST:0] vld_q;

  logic [31:0] u1_d, u2_d;
  logic [31:0] u1_q, u2_q;
  logic [31:0] om_u1;
  logic [28:0] lg1, lg1m, lg2;

  logic [63:0] u1sq_full, zq_full;
  logic [31:0] u1sq_q, u2d_q;
  logic [31:0] zq_q [2:LOG_LAT];

  logic [29:0] d_diff;
  logic [31:0] e_sum;
  logic        dneg_q;
  logic [28:0] dmag_q;
  logic        eneg_q;
  logic [30:0] emag_q;
  logic [31:0] zq26_q;

  logic [53:0]        lprod;
  logic [54:0]        zprod;
  logic               vneg27_q;
  logic [28:0]        lmag_q;
  logic signed [31:0] lnz27_q;
  logic [31:0]        zq27_q;

  logic [60:0]        vprod;
  logic               vneg28_q;
  logic [44:0]        vmag28_q;
  logic signed [31:0] lnz28_q;
  logic [31:0]        zq28_q;

  logic [53:0] tprod_hi;
  logic [40:0] tprod_lo;
  logic [54:0] tmag;
  logic        vneg29_q;
  logic [44:0] vmag29_q;
  gvr_side_t   side29_q;

  logic [40:0] x_e;
  gvr_side_t   side_e;

  logic [57:0]        r_d;
  logic [57:0]        r_q;
  logic [40:0]        x58_q;
  logic signed [31:0] lnz58_q;
  logic [31:0]        zq58_q;

  logic [57:0] s_sum;
  logic [35:0] zq9;
  logic        acc_sq;
  logic        acc_ln;
  logic        sat;

  logic        out_vld_q;
  logic [31:0] out_data_q;
  logic        out_sat_q;

  gvr_derive u_derive (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .terms_o     (terms)
  );

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en && cfg_ready_o;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign u1_d          = norm_uniform(s_axis_tdata[31:0]);
  assign u2_d          = norm_uniform(s_axis_tdata[63:32]);
  assign in_live       = in_xfer && (u1_d != 32'd0) && (u2_d != 32'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[PIPE_LAST-1:0], in_live};
      out_vld_q <= vld_q[PIPE_LAST] && (acc_sq || acc_ln);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_q <= u1_d;
      u2_q <= u2_d;
    end
  end

  assign om_u1 = 32'(33'h1_0000_0000 - {1'b0, u1_q});

  gvr_log2 u_log1 (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (u1_q),
    .lg_o  (lg1)
  );

  gvr_log2 u_log1m (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (om_u1),
    .lg_o  (lg1m)
  );

  gvr_log2 u_log2 (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (u2_q),
    .lg_o  (lg2)
  );

  assign u1sq_full = u1_q * u1_q;
  assign zq_full   = u1sq_q * u2d_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1sq_q  <= u1sq_full[63:32];
      u2d_q   <= u2_q;
      zq_q[2] <= zq_full[63:32];
      for (int i = 3; i <= LOG_LAT; i++) begin
        zq_q[i] <= zq_q[i-1];
      end
    end
  end

  assign d_diff = {1'b0, lg1} - {1'b0, lg1m};
  assign e_sum  = {2'd0, lg1, 1'b0} + {3'd0, lg2} - LOG2_96_Q24;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dneg_q <= d_diff[29];
      dmag_q <= d_diff[29] ? 29'(-d_diff) : d_diff[28:0];
      eneg_q <= e_sum[31];
      emag_q <= e_sum[31] ? 31'(-e_sum) : e_sum[30:0];
      zq26_q <= zq_q[LOG_LAT];
    end
  end

  assign lprod = dmag_q * LN2_Q24 + (54'd1 << 23);
  assign zprod = emag_q * LN2_Q24 + (55'd1 << 23);

  always_ff @(posedge clk_i) begin
    if (en) begin
      vneg27_q <= dneg_q;
      lmag_q   <= lprod[52:24];
      lnz27_q  <= eneg_q ? -$signed({1'b0, zprod[54:24]}) : $signed({1'b0, zprod[54:24]});
      zq27_q   <= zq26_q;
    end
  end

  assign vprod = lmag_q * terms.inv;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vneg28_q <= vneg27_q;
      vmag28_q <= vprod[60:16];
      lnz28_q  <= lnz27_q;
      zq28_q   <= zq27_q;
    end
  end

  assign tprod_hi = terms.slope * vmag28_q[44:16];
  assign tprod_lo = terms.slope * vmag28_q[15:0];
  assign tmag     = {1'b0, tprod_hi} + {30'd0, tprod_lo[40:16]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      vneg29_q       <= vneg28_q;
      vmag29_q       <= vmag28_q;
      side29_q.sterm <= vneg28_q ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
      side29_q.lnz   <= lnz28_q;
      side29_q.zq    <= zq28_q;
    end
  end

  gvr_exp u_exp (
    .clk_i   (clk_i),
    .en_i    (en),
    .v_neg_i (vneg29_q),
    .v_mag_i (vmag29_q),
    .shape_i (terms.shape),
    .side_i  (side29_q),
    .x_o     (x_e),
    .side_o  (side_e)
  );

  assign r_d = {{25{terms.offset[24]}}, terms.offset, 8'd0}
             + {{2{side_e.sterm[55]}}, side_e.sterm}
             - {17'd0, x_e};

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q     <= r_d;
      x58_q   <= x_e;
      lnz58_q <= side_e.lnz;
      zq58_q  <= side_e.zq;
    end
  end

  assign s_sum  = r_q + SQUEEZE_Q24;
  assign zq9    = zq58_q * 36'd9;
  assign acc_sq = !s_sum[57] && ({s_sum[54:0], 9'd0} >= {28'd0, zq9});
  assign acc_ln = $signed(r_q) >= $signed({{26{lnz58_q[31]}}, lnz58_q});
  assign sat    = (x58_q >= CAND_MAX);

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= sat ? 32'hFFFF_FFFF : x58_q[39:8];
      out_sat_q  <= sat;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_sat_q;

`ifndef SYNTH
  a_stall_holds_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_no_input_while_deriving : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_ready_o |-> !(s_axis_tvalid && s_axis_tready))
    else $error("input transfer while envelope terms are recomputed");

  a_result_from_last_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_q[PIPE_LAST]))
    else $error("result appeared without a live item in the last stage");
`endif

endmodule

### bench/tb_top.sv
// Self-checking testbench for the gamma rejection step: stream driver, monitor and predictor.
`timescale 1ns / 1ps
module tb_top;
  import gvr_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 90;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [31:0] sample_q16;
    logic        saturated;
  } sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [23:0] cfg_data_i = '0;

  logic [63:0] pair_queue[$];
  sample_t     sample_queue[$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;
  bit          hold_request = 1'b0;

  logic [23:0] shape_reg;
  logic [31:0] inv_scale;
  logic [31:0] offset_q16;
  logic [31:0] slope_q16;
  logic [63:0] exp_steps[24];

  gamma_variate_rejection_step dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem  = x;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic signed [63:0] log2_fix(input logic [31:0] x);
    int          msb;
    logic [63:0] y;
    logic [63:0] frac;
    msb = 31;
    while (msb > 0 && !x[msb]) msb--;
    y = (msb >= 30) ? (64'(x) >> (msb - 30)) : (64'(x) << (30 - msb));
    frac = '0;
    for (int i = 23; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        frac[i] = 1'b1;
      end
    end
    return (64'(msb) << 24) + frac;
  endfunction

  function automatic logic signed [63:0] mul_round(input logic signed [63:0] x,
                                                   input logic [63:0] c);
    logic [63:0] mag;
    mag = x < 0 ? 64'(-x) : 64'(x);
    mag = (mag * c + (64'd1 << 23)) >> 24;
    return x < 0 ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic void set_shape(input logic [23:0] shape);
    logic [63:0] a;
    logic [63:0] aa;
    logic [63:0] inv;
    shape_reg = shape;
    a = shape != 0 ? 64'(shape) : 64'd1;
    aa = (a > 64'd65536) ? int_sqrt((2 * a - 64'd65536) << 16) : a;
    inv = (64'd1 << 32) / aa;
    inv_scale  = inv > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : inv[31:0];
    offset_q16 = 32'(a - 64'd90852);
    slope_q16  = 32'(a + aa);
  endfunction

  function automatic logic signed [63:0] candidate(input logic [63:0] a,
                                                   input logic signed [63:0] v);
    logic signed [63:0] t;
    logic signed [63:0] k;
    logic signed [63:0] sh;
    logic [23:0]        f;
    logic [63:0]        m;
    logic [63:0]        prod;
    logic [63:0]        cap;
    cap = 64'd1 << 40;
    if (v >= (64'sd128 <<< 24)) return cap;
    if (v < -(64'sd128 <<< 24)) return 0;
    t = mul_round(v, 64'd24204406);
    k = t >>> 24;
    f = t[23:0];
    m = 64'd1 << 30;
    for (int i = 0; i < 24; i++) if (f[23 - i]) m = (m * exp_steps[i]) >> 30;
    prod = a * m;
    sh = 22 - k;
    if (sh >= 64) return 0;
    if (sh >= 0) prod = prod >> sh;
    else begin
      if (-sh >= 40 || prod > (cap >> (-sh))) return cap;
      prod = prod << (-sh);
    end
    return prod >= cap ? cap : prod;
  endfunction

  function automatic bit attempt(input logic [63:0] pair, output sample_t res);
    logic [31:0]        u1;
    logic [31:0]        u2;
    logic [63:0]        a;
    logic signed [63:0] lg1;
    logic signed [63:0] lg1m;
    logic signed [63:0] lg2;
    logic signed [63:0] lr;
    logic signed [63:0] v;
    logic signed [63:0] x;
    logic signed [63:0] sterm;
    logic signed [63:0] r;
    logic signed [63:0] s;
    logic signed [63:0] lnz;
    logic [63:0]        lmag;
    logic [63:0]        vmag;
    logic [63:0]        tmag;
    logic [63:0]        zq;
    bit                 ok;
    u1 = (pair[31:0] & UNIFORM_MASK) << (32 - UNIFORM_BITS);
    u2 = (pair[63:32] & UNIFORM_MASK) << (32 - UNIFORM_BITS);
    res = '0;
    if (u1 == 0 || u2 == 0) return 0;
    a = shape_reg != 0 ? 64'(shape_reg) : 64'd1;
    lg1  = log2_fix(u1);
    lg1m = log2_fix(32'((64'd1 << 32) - 64'(u1)));
    lg2  = log2_fix(u2);
    lr = mul_round(lg1 - lg1m, 64'd11629080);
    lmag = lr < 0 ? 64'(-lr) : 64'(lr);
    vmag = (lmag * 64'(inv_scale)) >> 16;
    v = lr < 0 ? -$signed(vmag) : $signed(vmag);
    x = candidate(a, v);
    tmag = 64'(slope_q16) * (vmag >> 16) + ((64'(slope_q16) * (vmag & 64'hFFFF)) >> 16);
    sterm = lr < 0 ? -$signed(tmag) : $signed(tmag);
    r = 64'($signed(offset_q16)) * 256 + sterm - x;
    zq = ((((64'(u1) * 64'(u1)) >> 32) * 64'(u2)) >> 32);
    s = r + 64'sd42011447;
    ok = (s >= 0) && (64'(s) * 64'd512 >= 64'd9 * zq);
    if (!ok) begin
      lnz = mul_round(2 * lg1 + lg2 - (64'sd96 <<< 24), 64'd11629080);
      ok = r >= lnz;
    end
    if (!ok) return 0;
    if (x >= (64'sd1 <<< 40)) res = '{32'hFFFF_FFFF, 1'b1};
    else res = '{32'(x >> 8), 1'b0};
    return 1;
  endfunction

  // Driver: gaps in bursts, hold data until transfer.
  int gap_count = 0;
  always @(posedge clk_i) begin
    sample_t     res;
    logic        next_valid;
    logic [63:0] next_data;
    next_valid = s_axis_tvalid;
    next_data  = s_axis_tdata;
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (attempt(s_axis_tdata, res)) sample_queue.push_back(res);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_count > 0) gap_count--;
        else if (!quiet && $urandom_range(0, 9) == 0) gap_count = $urandom_range(1, 6);
        else if (pair_queue.size() > 0) begin
          next_valid = 1'b1;
          next_data  = pair_queue.pop_front();
        end
      end
    end
    s_axis_tvalid <= next_valid;
    s_axis_tdata  <= next_data;
  end

  // Monitor: random stalls plus one long hold-off.
  int  stall_count = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk_i) begin
    sample_t want;
    logic    next_ready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sample_queue.size() == 0) begin
        $error("unexpected sample_q16 %h", m_axis_tdata);
        error_count++;
      end else begin
        want = sample_queue.pop_front();
        if (m_axis_tdata !== want.sample_q16) begin
          $error("sample_q16 expected %h actual %h", want.sample_q16, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser[0] !== want.saturated) begin
          $error("saturated expected %b actual %b", want.saturated, m_axis_tuser[0]);
          error_count++;
        end
      end
    end
    next_ready = 1'b1;
    if (stall_count > 0) begin
      stall_count--;
      next_ready = 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      stall_count = HOLD_CYCLES;
      next_ready = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_count = $urandom_range(0, 5);
      next_ready = 1'b0;
    end
    m_axis_tready <= next_ready;
  end

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pair_queue.size() != 0 || s_axis_tvalid || sample_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_shape(input logic [23:0] shape);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= shape;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    set_shape(shape);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_uniform();
    case ($urandom_range(0, 5))
      0: return $urandom_range(1, 65535);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 65535);
      default: return $urandom;
    endcase
  endfunction

  task automatic load_random(input int n);
    for (int i = 0; i < n; i++) pair_queue.push_back({rand_uniform(), rand_uniform()});
  endtask

  logic [23:0] shapes[7] = '{24'd1, 24'd16777215, 24'd0, 24'd32768,
                             24'd131072, 24'd360448, 24'd65537};

  initial begin
    exp_steps[0] = int_sqrt(64'd1 << 61);
    for (int i = 1; i < 24; i++) exp_steps[i] = int_sqrt(exp_steps[i - 1] << 30);
    set_shape(24'd65536);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, tiny and huge ratios, zero uniforms
    pair_queue.push_back({32'd1, 32'd1});
    pair_queue.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF});
    pair_queue.push_back({32'hFFFF_FFFF, 32'd1});
    pair_queue.push_back({32'd1, 32'hFFFF_FFFF});
    pair_queue.push_back({32'h8000_0000, 32'h8000_0000});
    pair_queue.push_back({32'h0000_0000, 32'h8000_0000});
    pair_queue.push_back({32'h8000_0000, 32'h0000_0000});
    pair_queue.push_back({32'h5555_5555, 32'hAAAA_AAAA});
    pair_queue.push_back({32'hAAAA_AAAA, 32'h5555_5555});
    pair_queue.push_back({32'h7FFF_FFFF, 32'h0000_0100});
    load_random(190);
    hold_request = 1'b1;
    wait_idle();

    foreach (shapes[i]) begin
      write_shape(shapes[i]);
      pair_queue.push_back({32'hFFFF_FFFF, 32'd1});
      pair_queue.push_back({32'd1, 32'hFFFF_FFFF});
      pair_queue.push_back({32'h0000_0000, 32'hFFFF_FFFF});
      load_random(170);
      if (i == $size(shapes) - 1) quiet = 1'b1;
      wait_idle();
    end

    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
design/gvr_pkg.sv
design/gvr_derive.sv
design/gvr_log2.sv
design/gvr_exp.sv
design/gamma_variate_rejection_step.sv
bench/tb_top.sv
